// ===== hw/rtl/video_unit_register_port_defines.svh =====
// Assertion macros used by the checker file of the video unit register port.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef VIDEO_UNIT_REGISTER_PORT_DEFINES_SVH
`define VIDEO_UNIT_REGISTER_PORT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define VUR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("video unit register port check failed");

// A signal holds while its word is stalled.
`define VUR_ASSERT_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("stalled word changed");

`endif

// ===== hw/rtl/vur_pkg.sv =====
// Types and constants of the video unit register port.
// No dependencies; imported by the timer, register, output buffer and top-level modules.
`default_nettype none

package vur_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_t;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam int DOT_W  = 9;
  localparam int LINE_W = 10;

  localparam logic signed [LINE_W-1:0] LINE_PRE    = -10'sd1;
  localparam logic signed [LINE_W-1:0] LINE_VBLANK = 10'sd241;
  localparam logic [DOT_W-1:0]         DOT_EVENT   = 9'd1;

  localparam logic [13:0] PAL_BASE    = 14'h3F00;
  localparam logic [7:0]  PAL_MASK    = 8'h3F;
  localparam logic [7:0]  GRAY_MASK   = 8'h30;
  localparam logic [15:0] STEP_ACROSS = 16'd1;
  localparam logic [15:0] STEP_DOWN   = 16'd32;

  typedef struct packed {
    logic vbl_set;
    logic vbl_clr;
    logic frame_done;
  } timer_ev_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_raise;
    logic       frame_done;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vur_cmd_if.sv =====
// Command channel of the video unit register port: valid/ready plus one item.
// No dependencies.
`default_nettype none

interface vur_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] reg_addr;
  logic [7:0] write_data;

  modport source (output valid, opcode, reg_addr, write_data, input ready);
  modport sink   (input valid, opcode, reg_addr, write_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vur_rsp_if.sv =====
// Result channel of the video unit register port: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface vur_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nmi_raise;
  logic       frame_done;

  modport source (output valid, read_data, nmi_raise, frame_done, input ready);
  modport sink   (input valid, read_data, nmi_raise, frame_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vur_timer.sv =====
// Dot and line counters of the frame timer; flags vblank edges and frame wrap.
// Depends on vur_pkg.
`default_nettype none

module vur_timer #(
  parameter int DOTS_PER_LINE = 341,
  parameter int LAST_LINE     = 261
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               tick,
  output vur_pkg::timer_ev_t      ev
);
  import vur_pkg::*;

  logic        [DOT_W-1:0]  dot;
  logic signed [LINE_W-1:0] line;
  logic        [DOT_W:0]    dot_inc;
  logic signed [LINE_W-1:0] line_inc;
  logic                     dot_wrap;
  logic                     line_wrap;

  assign dot_inc   = {1'b0, dot} + (DOT_W+1)'(1);
  assign line_inc  = line + LINE_W'(1);
  assign dot_wrap  = dot_inc >= (DOT_W+1)'(DOTS_PER_LINE);
  assign line_wrap = line_inc >= $signed(LINE_W'(LAST_LINE));

  assign ev.vbl_clr    = tick && (line == LINE_PRE) && (dot == DOT_EVENT);
  assign ev.vbl_set    = tick && (line == LINE_VBLANK) && (dot == DOT_EVENT);
  assign ev.frame_done = tick && dot_wrap && line_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot  <= '0;
      line <= '0;
    end else if (tick) begin
      if (dot_wrap) begin
        dot  <= '0;
        line <= line_wrap ? LINE_PRE : line_inc;
      end else begin
        dot <= dot_inc[DOT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vur_regs.sv =====
// Register file of the video unit: control, mask, status, address latch and
// the buffered data port into the pattern memory and palette. Depends on vur_pkg.
`default_nettype none

module vur_regs #(
  parameter int PATTERN_BYTES = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [1:0]         opcode,
  input  wire logic [2:0]         reg_addr,
  input  wire logic [7:0]         write_data,
  input  wire vur_pkg::timer_ev_t ev,
  output vur_pkg::result_t        res
);
  import vur_pkg::*;

  localparam int PAT_AW = $clog2(PATTERN_BYTES);

  logic [7:0]  control;
  logic [7:0]  mask;
  logic        vblank;
  logic        high_done;
  logic [15:0] ptr;
  logic [7:0]  buf_reg;
  logic        buf_from_mem;
  logic [7:0]  pat_q;
  logic [7:0]  pal [32];
  logic [7:0]  pat_mem [PATTERN_BYTES];

  logic [13:0]       mem_addr;
  logic              in_pat;
  logic              in_pal;
  logic [4:0]        pal_idx;
  logic [7:0]        pal_rd;
  logic [7:0]        cur_buf;
  logic [13:0]       pat_wide;
  logic [PAT_AW-1:0] pat_idx;
  logic [15:0]       step;
  logic              is_read;
  logic              is_write;
  logic              rd_status;
  logic              rd_data;
  logic              wr_data;

  assign mem_addr = ptr[13:0];
  assign in_pat   = !mem_addr[13];
  assign in_pal   = mem_addr >= PAL_BASE;

  // entries 0x10/0x14/0x18/0x1C alias the background entries
  always_comb begin
    pal_idx = ptr[4:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  assign pal_rd  = pal[pal_idx] & (mask[0] ? GRAY_MASK : PAL_MASK);
  assign cur_buf = buf_from_mem ? pat_q : buf_reg;

  // the 13-bit address is below twice the store size, so one subtract folds it
  assign pat_wide = ({1'b0, mem_addr[12:0]} >= 14'(PATTERN_BYTES))
                    ? ({1'b0, mem_addr[12:0]} - 14'(PATTERN_BYTES))
                    : {1'b0, mem_addr[12:0]};
  assign pat_idx  = pat_wide[PAT_AW-1:0];

  assign step = control[2] ? STEP_DOWN : STEP_ACROSS;

  assign is_read   = en && (opcode == OP_READ);
  assign is_write  = en && (opcode == OP_WRITE);
  assign rd_status = is_read && (reg_addr == REG_STATUS);
  assign rd_data   = is_read && (reg_addr == REG_DATA);
  assign wr_data   = is_write && (reg_addr == REG_DATA);

  always_comb begin
    res.read_data  = '0;
    res.nmi_raise  = ev.vbl_set && control[7];
    res.frame_done = ev.frame_done;
    if (rd_status) begin
      res.read_data = {vblank, 2'b00, cur_buf[4:0]};
    end else if (rd_data) begin
      res.read_data = in_pal ? pal_rd : cur_buf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control      <= '0;
      mask         <= '0;
      vblank       <= 1'b0;
      high_done    <= 1'b0;
      ptr          <= '0;
      buf_reg      <= '0;
      buf_from_mem <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        pal[i] <= '0;
      end
    end else begin
      if (ev.vbl_set) begin
        vblank <= 1'b1;
      end else if (ev.vbl_clr || rd_status) begin
        vblank <= 1'b0;
      end
      if (rd_status) begin
        high_done <= 1'b0;
      end
      if (rd_data) begin
        buf_from_mem <= in_pat;
        if (!in_pat) begin
          buf_reg <= in_pal ? pal_rd : 8'h00;
        end
      end
      if (rd_data || wr_data) begin
        ptr <= ptr + step;
      end
      if (wr_data && in_pal) begin
        pal[pal_idx] <= write_data;
      end
      if (is_write) begin
        case (reg_addr)
          REG_CONTROL: control <= write_data;
          REG_MASK:    mask    <= write_data;
          REG_ADDR: begin
            if (!high_done) begin
              ptr <= {2'b00, write_data[5:0], ptr[7:0]};
            end else begin
              ptr <= {ptr[15:8], write_data};
            end
            high_done <= !high_done;
          end
          default: ;
        endcase
      end
    end
  end

  // pattern memory: one write or one read per word, read data registered
  always_ff @(posedge clk) begin
    if (wr_data && in_pat) begin
      pat_mem[pat_idx] <= write_data;
    end
    if (rd_data && in_pat) begin
      pat_q <= pat_mem[pat_idx];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vur_out_buf.sv =====
// Result register with a skid stage, so a word can be taken while the last
// result waits. Depends on vur_pkg and vur_rsp_if.
`default_nettype none

module vur_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire vur_pkg::result_t data,
  output logic                  ready,
  vur_rsp_if.source             rsp
);
  import vur_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t out_word;
  result_t skid_word;
  logic    take;
  logic    load_out;

  assign take     = out_valid && rsp.ready;
  assign ready    = !skid_valid;
  assign load_out = push && (!out_valid || take);

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_word.read_data;
  assign rsp.nmi_raise  = out_word.nmi_raise;
  assign rsp.frame_done = out_word.frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !load_out) begin
      skid_word <= data;
    end
    if (load_out) begin
      out_word <= data;
    end else if (!push && take && skid_valid) begin
      out_word <= skid_word;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/video_unit_register_port.sv =====
// Top level of the video unit register port and frame timer.
// Depends on vur_pkg, vur_cmd_if, vur_rsp_if, vur_timer, vur_regs, vur_out_buf.
//
//   channel  dir  word
//   cmd      in   opcode, reg_addr, write_data
//   rsp      out  read_data, nmi_raise, frame_done
//
// One word in per cycle while cmd.ready is high; its result is registered in the output or skid word for rsp.
// All state updates in the accept cycle; the pattern memory read is registered
// and feeds the read buffer directly on later words.
// A stalled rsp is absorbed by one skid word; cmd.ready drops only when it is full.
// Synchronous reset clears the state registers, valid flags and palette; the pattern
// memory, its read register and the result words are not cleared.
`default_nettype none

module video_unit_register_port #(
  parameter int PATTERN_BYTES = 8192,
  parameter int DOTS_PER_LINE = 341,
  parameter int LAST_LINE     = 261
) (
  input wire logic  clk,
  input wire logic  rst,
  vur_cmd_if.sink   cmd,
  vur_rsp_if.source rsp
);
  import vur_pkg::*;

  logic      accept;
  logic      tick;
  logic      buf_ready;
  timer_ev_t ev;
  result_t   res;

  assign cmd.ready = buf_ready;
  assign accept    = cmd.valid && buf_ready;
  assign tick      = accept && (cmd.opcode == OP_TICK);

  vur_timer #(
    .DOTS_PER_LINE (DOTS_PER_LINE),
    .LAST_LINE     (LAST_LINE)
  ) u_timer (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .ev   (ev)
  );

  vur_regs #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .opcode     (cmd.opcode),
    .reg_addr   (cmd.reg_addr),
    .write_data (cmd.write_data),
    .ev         (ev),
    .res        (res)
  );

  vur_out_buf u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .data  (res),
    .ready (buf_ready),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vur_checker.sv =====
// Port-level checks of the video unit register port, bound to the top level.
// Depends on video_unit_register_port_defines.svh.
`default_nettype none
`include "video_unit_register_port_defines.svh"

module vur_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cmd_valid,
  input wire logic       cmd_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_read_data,
  input wire logic       rsp_nmi_raise,
  input wire logic       rsp_frame_done
);

  // a tick word never carries read data, and vblank start is not a frame wrap
  `VUR_ASSERT_IMPLY(a_nmi_alone, rsp_valid && rsp_nmi_raise, (rsp_read_data == 8'h00) && !rsp_frame_done)
  `VUR_ASSERT_IMPLY(a_wrap_alone, rsp_valid && rsp_frame_done, rsp_read_data == 8'h00)
  // a result only appears from an empty output after a word was taken
  `VUR_ASSERT_IMPLY(a_rsp_from_cmd, $rose(rsp_valid), $past(cmd_valid && cmd_ready))
  `VUR_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, {rsp_read_data, rsp_nmi_raise, rsp_frame_done})

endmodule

bind video_unit_register_port vur_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_data  (rsp.read_data),
  .rsp_nmi_raise  (rsp.nmi_raise),
  .rsp_frame_done (rsp.frame_done)
);

`default_nettype wire
